@@ src/i2c_ram_pkg.sv @@
package i2c_ram_pkg;

  localparam int MaxBytes = 16;
  localparam int BufAw = (MaxBytes > 1) ? $clog2(MaxBytes) : 1;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'd0,
    S_START  = 4'd1,
    S_ADDR   = 4'd2,
    S_SUB    = 4'd3,
    S_DATA   = 4'd4,
    S_RADDR  = 4'd5,
    S_RSTART = 4'd6,
    S_WAIT   = 4'd7,
    S_GAP    = 4'd8,
    S_RX     = 4'd9,
    S_STOP   = 4'd10
  } seq_state_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ADDR_NACK = 3'd1,
    ST_SUB_NACK  = 3'd2,
    ST_RADDR_ERR = 3'd3,
    ST_DATA_NACK = 3'd4
  } status_t;

  localparam logic [2:0] CFG_TPP   = 3'd0;
  localparam logic [2:0] CFG_ATO   = 3'd1;
  localparam logic [2:0] CFG_MODE  = 3'd2;
  localparam logic [2:0] CFG_FWAIT = 3'd3;
  localparam logic [2:0] CFG_RETRY = 3'd4;
  localparam logic [2:0] CFG_GAP   = 3'd5;

  typedef struct packed {
    logic [1:0] cmd;
    logic [6:0] device_address;
    logic [7:0] sub_address;
    logic [4:0] length;
    logic [7:0] write_byte;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       rx_last;
    logic       done_res;
    logic [2:0] status;
    logic       busy_res;
  } out_word_t;

endpackage

@@ src/i2c_register_access_master.sv @@
// channel | direction | handshake                 | payload
// in_     | input     | in_valid / in_ready       | in_word_t (one tick per word)
// out_    | output    | out_valid / out_ready     | out_word_t (one result per word)
// cfg_    | input     | cfg_we, cfg_index         | cfg_data, 20 bits
// one word per cycle while out_ready is high: the sequencer steps once per accepted word, result registered
// out_valid rises in the cycle after a word is accepted; the single output register sets the rate
// in_ready is high while the output register is empty or being emptied
// a stall on out_ready holds the result and blocks further words
// reset (rst_n low, synchronous) returns to idle with default configuration
module i2c_register_access_master
  import i2c_ram_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int CntW = $clog2(MaxBytes + 1);

  logic [15:0] tpp_r, ato_r, retry_lim_r;
  logic        mode_r;
  logic [19:0] fwait_r;
  logic [7:0]  gap_r;

  seq_state_t  st_r, st_nxt;
  logic [1:0]  q_r, q_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [3:0]  bc_r, bc_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [CntW-1:0] byc_r, byc_nxt;
  logic [15:0] aw_r, aw_nxt;
  logic        ack_r, ack_nxt;
  logic [15:0] rc_r, rc_nxt;
  logic [19:0] wc_r, wc_nxt;
  logic [2:0]  rs_r, rs_nxt;
  logic [CntW-1:0] fill_r, fill_nxt;
  logic [6:0]  ta_r, ta_nxt;
  logic [7:0]  ra_r, ra_nxt;
  logic [CntW-1:0] rl_r, rl_nxt;
  logic        rd_r, rd_nxt;

  logic [7:0]  buf_mem [MaxBytes];
  logic        buf_we;
  logic [BufAw-1:0] buf_wa;
  logic [BufAw-1:0] buf_ra;
  logic [7:0]  buf_rd_r;

  out_word_t   res;
  out_word_t   out_r;
  logic        ov_r;
  logic        acc;

  assign in_ready  = !ov_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpp_r <= 16'd25; ato_r <= 16'd500; mode_r <= 1'b1;
      fwait_r <= 20'd10000; retry_lim_r <= 16'hffff; gap_r <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TPP:   tpp_r <= cfg_data[15:0];
        CFG_ATO:   ato_r <= cfg_data[15:0];
        CFG_MODE:  mode_r <= cfg_data[0];
        CFG_FWAIT: fwait_r <= cfg_data;
        CFG_RETRY: retry_lim_r <= cfg_data[15:0];
        CFG_GAP:   gap_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // next byte to send is prefetched while the current byte is on the bus
  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[buf_wa] <= in_data.write_byte;
    buf_rd_r <= buf_mem[buf_ra];
  end

  // combinational step
  always_comb begin
    logic [4:0] len;
    logic [CntW-1:0] bidx;
    logic [CntW-1:0] bsum;
    logic phase_end;
    logic sda;
    st_nxt = st_r; q_nxt = q_r; pc_nxt = pc_r; bc_nxt = bc_r; sh_nxt = sh_r;
    byc_nxt = byc_r; aw_nxt = aw_r; ack_nxt = ack_r; rc_nxt = rc_r; wc_nxt = wc_r;
    rs_nxt = rs_r; fill_nxt = fill_r; ta_nxt = ta_r; ra_nxt = ra_r; rl_nxt = rl_r;
    rd_nxt = rd_r;
    buf_we = 1'b0;
    buf_wa = fill_r[BufAw-1:0];
    buf_ra = (st_r == S_DATA) ? byc_r[BufAw-1:0] + BufAw'(1) : '0;
    res = '0;
    res.scl_level = 1'b1;
    res.sda_level = 1'b1;
    len = in_data.length;
    sda = in_data.sda_in;
    bidx = byc_r + CntW'(1);
    bsum = byc_r + CntW'(1);

    if (st_r == S_IDLE) begin
      if (in_data.cmd == CMD_LOAD) begin
        if (fill_r < CntW'(MaxBytes)) begin
          buf_we = 1'b1;
          fill_nxt = fill_r + CntW'(1);
        end
      end else if (in_data.cmd == CMD_WRITE || in_data.cmd == CMD_READ) begin
        ta_nxt = in_data.device_address;
        ra_nxt = in_data.sub_address;
        if (len == 5'd0) len = 5'd1;
        rl_nxt = (32'(len) > MaxBytes) ? CntW'(MaxBytes) : CntW'(len);
        rd_nxt = (in_data.cmd == CMD_READ);
        rs_nxt = ST_OK;
        st_nxt = S_START; q_nxt = '0; bc_nxt = '0; pc_nxt = '0;
      end
    end

    // line levels from the state entering this tick
    unique case (st_nxt)
      S_START, S_RSTART: begin
        res.scl_level = (q_nxt == 2'd1 || q_nxt == 2'd2);
        res.sda_level = (q_nxt < 2'd2);
        res.sda_drive = 1'b1;
      end
      S_STOP: begin
        res.scl_level = (q_nxt != 2'd0);
        res.sda_level = (q_nxt >= 2'd2);
        res.sda_drive = 1'b1;
      end
      S_WAIT, S_GAP: res.scl_level = 1'b0;
      S_RX: begin
        res.scl_level = (q_nxt == 2'd1 || q_nxt == 2'd2);
        if (bc_nxt >= 4'd8) begin
          res.sda_drive = 1'b1;
          res.sda_level = (byc_nxt + CntW'(1) >= rl_nxt);
        end
      end
      S_IDLE: ;
      default: begin
        res.scl_level = (q_nxt == 2'd1 || q_nxt == 2'd2);
        if (bc_nxt < 4'd8) begin
          res.sda_drive = 1'b1;
          res.sda_level = sh_nxt[3'd7 - bc_nxt[2:0]];
        end
      end
    endcase

    // advance; all reads below use the _nxt view set above
    phase_end = ({16'd0, pc_nxt} + 32'd1) >= {16'd0, tpp_r};
    if ((st_nxt == S_ADDR || st_nxt == S_SUB || st_nxt == S_DATA || st_nxt == S_RADDR)
        && bc_nxt >= 4'd8 && q_nxt == 2'd2) begin
      if (!sda) begin
        ack_nxt = 1'b1; q_nxt = 2'd3; pc_nxt = '0;
      end else begin
        aw_nxt = aw_nxt + 16'd1;
        if (aw_nxt >= ato_r) begin
          ack_nxt = 1'b0; q_nxt = 2'd3; pc_nxt = '0;
        end
      end
    end else if (!phase_end) begin
      pc_nxt = pc_nxt + 16'd1;
    end else begin
      pc_nxt = '0;
      unique case (st_nxt)
        S_START, S_RSTART: begin
          if (q_nxt < 2'd3) q_nxt = q_nxt + 2'd1;
          else begin
            sh_nxt = {ta_nxt, st_nxt == S_RSTART};
            st_nxt = (st_nxt == S_START) ? S_ADDR : S_RADDR;
            q_nxt = '0; bc_nxt = '0;
          end
        end
        S_WAIT: begin
          wc_nxt = wc_nxt + 20'd1;
          if (wc_nxt >= fwait_r) begin
            byc_nxt = '0; st_nxt = S_RX; q_nxt = '0; bc_nxt = '0; sh_nxt = '0;
          end
        end
        S_GAP: begin
          wc_nxt = wc_nxt + 20'd1;
          if (wc_nxt >= 20'(gap_r)) begin
            st_nxt = S_RSTART; q_nxt = '0; bc_nxt = '0;
          end
        end
        S_STOP: begin
          if (q_nxt < 2'd3) q_nxt = q_nxt + 2'd1;
          else begin
            res.done_res = 1'b1;
            res.status = rs_nxt;
            if (!rd_nxt) fill_nxt = '0;
            st_nxt = S_IDLE; q_nxt = '0; bc_nxt = '0;
          end
        end
        S_RX: begin
          if (q_nxt == 2'd1 && bc_nxt < 4'd8) begin
            sh_nxt = {sh_nxt[6:0], sda};
            if (bc_nxt == 4'd7) begin
              res.rx_byte = sh_nxt;
              res.rx_valid = 1'b1;
              res.rx_last = (byc_nxt + CntW'(1) >= rl_nxt);
            end
          end
          if (q_nxt < 2'd3) q_nxt = q_nxt + 2'd1;
          else if (bc_nxt < 4'd8) begin
            bc_nxt = bc_nxt + 4'd1; q_nxt = '0;
          end else begin
            byc_nxt = byc_nxt + CntW'(1);
            q_nxt = '0; bc_nxt = '0;
            if (byc_nxt >= rl_nxt) begin
              rs_nxt = ST_OK; st_nxt = S_STOP;
            end else sh_nxt = '0;
          end
        end
        S_IDLE: ;
        default: begin
          if (q_nxt == 2'd1 && bc_nxt >= 4'd8) begin
            q_nxt = 2'd2; aw_nxt = '0; ack_nxt = 1'b0;
          end else if (q_nxt < 2'd3) q_nxt = q_nxt + 2'd1;
          else if (bc_nxt < 4'd8) begin
            bc_nxt = bc_nxt + 4'd1; q_nxt = '0;
          end else begin
            q_nxt = '0; bc_nxt = '0;
            unique case (st_nxt)
              S_ADDR: begin
                if (ack_nxt) begin
                  sh_nxt = ra_nxt; st_nxt = S_SUB;
                end else begin
                  rs_nxt = ST_ADDR_NACK; st_nxt = S_STOP;
                end
              end
              S_SUB: begin
                if (!ack_nxt) begin
                  rs_nxt = ST_SUB_NACK; st_nxt = S_STOP;
                end else if (rd_nxt) begin
                  rc_nxt = '0;
                  if (mode_r) begin
                    wc_nxt = '0;
                    st_nxt = (gap_r == 8'd0) ? S_RSTART : S_GAP;
                  end else st_nxt = S_RSTART;
                end else if (fill_nxt != '0) begin
                  byc_nxt = '0; sh_nxt = buf_rd_r; st_nxt = S_DATA;
                end else begin
                  rs_nxt = ST_OK; st_nxt = S_STOP;
                end
              end
              S_DATA: begin
                if (!ack_nxt) begin
                  rs_nxt = ST_DATA_NACK; st_nxt = S_STOP;
                end else begin
                  byc_nxt = bsum;
                  if (bidx < fill_nxt && 32'(bidx) < MaxBytes) begin
                    sh_nxt = buf_rd_r; st_nxt = S_DATA;
                  end else begin
                    rs_nxt = ST_OK; st_nxt = S_STOP;
                  end
                end
              end
              default: begin
                if (ack_nxt) begin
                  if (!mode_r && fwait_r != 20'd0) begin
                    wc_nxt = '0; st_nxt = S_WAIT;
                  end else begin
                    byc_nxt = '0; st_nxt = S_RX; sh_nxt = '0;
                  end
                end else if (mode_r) begin
                  rc_nxt = rc_nxt + 16'd1;
                  if (rc_nxt >= retry_lim_r) begin
                    rs_nxt = ST_RADDR_ERR; st_nxt = S_STOP;
                  end else begin
                    wc_nxt = '0;
                    st_nxt = (gap_r == 8'd0) ? S_RSTART : S_GAP;
                  end
                end else begin
                  rs_nxt = ST_RADDR_ERR; st_nxt = S_STOP;
                end
              end
            endcase
          end
        end
      endcase
    end
    res.busy_res = (st_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; q_r <= '0; pc_r <= '0; bc_r <= '0; sh_r <= '0; byc_r <= '0;
      aw_r <= '0; ack_r <= 1'b0; rc_r <= '0; wc_r <= '0; rs_r <= '0; fill_r <= '0;
      ta_r <= '0; ra_r <= '0; rl_r <= '0; rd_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (acc) begin
        st_r <= st_nxt; q_r <= q_nxt; pc_r <= pc_nxt; bc_r <= bc_nxt; sh_r <= sh_nxt;
        byc_r <= byc_nxt; aw_r <= aw_nxt; ack_r <= ack_nxt; rc_r <= rc_nxt;
        wc_r <= wc_nxt; rs_r <= rs_nxt; fill_r <= fill_nxt; ta_r <= ta_nxt;
        ra_r <= ra_nxt; rl_r <= rl_nxt; rd_r <= rd_nxt;
      end
      if (acc) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) out_r <= res;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CntW'(MaxBytes)) else $error("buffer fill overflow");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_r.done_res |-> !out_r.busy_res) else $error("done while busy");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable(out_r) && $stable(st_r))
    else $error("stalled result lost");
  a_rx_scl: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_r.rx_valid |-> out_r.scl_level && !out_r.sda_drive)
    else $error("rx sample outside scl high");

endmodule
